/* hdl/assert_macros.svh */
// Assertion macros shared by the RTL files of the dual moving average block.
// No dependencies; include by bare file name inside a module body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed: always");

// When the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// When the antecedent holds, the consequent must hold in the following cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

/* hdl/dmad_pkg.sv */
// Shared constants and types for the dual moving average deadband filter.
// No dependencies.
`default_nettype none

package dmad_pkg;

  localparam int WINDOW_LENGTH = 16;
  localparam int SAMPLE_W      = 16;
  localparam int SUM_W         = 24;
  localparam int DB_W          = 8;
  localparam int PTR_W         = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
  localparam int CNT_W         = $clog2(WINDOW_LENGTH + 1);
  localparam int DIV_CNT_W     = $clog2(SUM_W + 1);

  localparam logic [DB_W-1:0] DB_RESET = DB_W'(2);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIVIDE
  } state_t;

endpackage

`default_nettype wire

/* hdl/dmad_div.sv */
// Restoring divider, one quotient bit per cycle, window sum by fill count.
// Depends on dmad_pkg and assert_macros.svh.
`default_nettype none

module dmad_div (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [dmad_pkg::SUM_W-1:0]   dividend,
  input  wire logic [dmad_pkg::CNT_W-1:0]   divisor,
  output logic                              done,
  output logic      [dmad_pkg::SUM_W-1:0]   quotient
);
  import dmad_pkg::*;
  `include "assert_macros.svh"

  logic [SUM_W-1:0]     dvd_r, dvd_nxt;
  logic [CNT_W-1:0]     rem_r, rem_nxt;
  logic [CNT_W-1:0]     dsr_r;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W:0]       rem_sh;
  logic                 ge;

  always_comb begin
    rem_sh  = {rem_r, dvd_r[SUM_W-1]};
    ge      = (rem_sh >= {1'b0, dsr_r});
    rem_nxt = ge ? CNT_W'(rem_sh - {1'b0, dsr_r}) : rem_sh[CNT_W-1:0];
    dvd_nxt = {dvd_r[SUM_W-2:0], ge};
    cnt_nxt = cnt_r - DIV_CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= DIV_CNT_W'(SUM_W);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (cnt_r != '0) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done     = (cnt_r == '0);
  assign quotient = dvd_r;

  `ASSERT_ALWAYS(a_div_cnt_range, clk, rst_n, cnt_r <= DIV_CNT_W'(SUM_W))
  `ASSERT_NEXT(a_div_start_busy, clk, rst_n, start, cnt_r == DIV_CNT_W'(SUM_W))
  `ASSERT_IMPLIES(a_div_start_idle, clk, rst_n, start, done)

endmodule

`default_nettype wire

/* hdl/dual_moving_average_deadband.sv */
// An accepted input transaction goes through ST_UPDATE and ST_DIVIDE before out_tvalid rises.
// in_tready stays low from acceptance until the 24-step divider's result is loaded for output.
// History lives in a 16-entry synchronous RAM holding both channels side by side.
// Reset (rst_n low, synchronous) clears fill count, pointer, sums, last values, valid flag.
// Deadband width resets to 2; the history RAM is not cleared and needs no clearing pass.
`default_nettype none

module dual_moving_average_deadband (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [15:0] voltage_sample, [31:16] current_sample
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [31:0] out_tdata   // [15:0] voltage_filtered, [31:16] current_filtered
);
  import dmad_pkg::*;
  `include "assert_macros.svh"

  state_t state_r, state_nxt;

  logic [2*SAMPLE_W-1:0] hist_mem [WINDOW_LENGTH];
  logic [2*SAMPLE_W-1:0] rd_data_r;
  logic                  mem_we;

  logic [SAMPLE_W-1:0] volt_r, cur_r;
  logic [PTR_W-1:0]    wp_r, wp_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [SUM_W-1:0]    vsum_r, vsum_nxt, csum_r, csum_nxt;
  logic [SAMPLE_W-1:0] vlast_r, vlast_nxt, clast_r, clast_nxt;
  logic [DB_W-1:0]     db_r;
  logic                out_tvalid_r, out_tvalid_nxt;
  logic [31:0]         out_tdata_r;

  logic                in_acc, full, div_start, out_load;
  logic                vdone, cdone;
  logic [SUM_W-1:0]    vquot, cquot;

  function automatic logic [SAMPLE_W-1:0] hold_value(input logic [SAMPLE_W-1:0] mean,
                                                     input logic [SAMPLE_W-1:0] last,
                                                     input logic [DB_W-1:0]     width);
    logic [SAMPLE_W-1:0] diff;
    diff = (mean >= last) ? (mean - last) : (last - mean);
    return (diff < SAMPLE_W'(width)) ? last : mean;
  endfunction

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign full      = (cnt_r == CNT_W'(WINDOW_LENGTH));

  always_comb begin
    state_nxt      = state_r;
    mem_we         = 1'b0;
    div_start      = 1'b0;
    out_load       = 1'b0;
    wp_nxt         = wp_r;
    cnt_nxt        = cnt_r;
    vsum_nxt       = vsum_r;
    csum_nxt       = csum_r;
    vlast_nxt      = vlast_r;
    clast_nxt      = clast_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        mem_we    = 1'b1;
        div_start = 1'b1;
        if (full) begin
          vsum_nxt = vsum_r - SUM_W'(rd_data_r[SAMPLE_W-1:0]) + SUM_W'(volt_r);
          csum_nxt = csum_r - SUM_W'(rd_data_r[2*SAMPLE_W-1:SAMPLE_W]) + SUM_W'(cur_r);
        end else begin
          vsum_nxt = vsum_r + SUM_W'(volt_r);
          csum_nxt = csum_r + SUM_W'(cur_r);
          cnt_nxt  = cnt_r + CNT_W'(1);
        end
        wp_nxt    = (wp_r == PTR_W'(WINDOW_LENGTH - 1)) ? '0 : wp_r + PTR_W'(1);
        state_nxt = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (vdone && cdone && (!out_tvalid_r || out_tready)) begin
          out_load       = 1'b1;
          out_tvalid_nxt = 1'b1;
          vlast_nxt      = hold_value(vquot[SAMPLE_W-1:0], vlast_r, db_r);
          clast_nxt      = hold_value(cquot[SAMPLE_W-1:0], clast_r, db_r);
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      wp_r         <= '0;
      cnt_r        <= '0;
      vsum_r       <= '0;
      csum_r       <= '0;
      vlast_r      <= '0;
      clast_r      <= '0;
      db_r         <= DB_RESET;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      wp_r         <= wp_nxt;
      cnt_r        <= cnt_nxt;
      vsum_r       <= vsum_nxt;
      csum_r       <= csum_nxt;
      vlast_r      <= vlast_nxt;
      clast_r      <= clast_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_wr_en) begin
        db_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      volt_r    <= in_tdata[SAMPLE_W-1:0];
      cur_r     <= in_tdata[2*SAMPLE_W-1:SAMPLE_W];
      rd_data_r <= hist_mem[wp_r];
    end
    if (mem_we) begin
      hist_mem[wp_r] <= {cur_r, volt_r};
    end
    if (out_load) begin
      out_tdata_r <= {clast_nxt, vlast_nxt};
    end
  end

  dmad_div u_vdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (vsum_nxt),
    .divisor  (cnt_nxt),
    .done     (vdone),
    .quotient (vquot)
  );

  dmad_div u_cdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (csum_nxt),
    .divisor  (cnt_nxt),
    .done     (cdone),
    .quotient (cquot)
  );

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  `ASSERT_ALWAYS(a_cnt_range, clk, rst_n, cnt_r <= CNT_W'(WINDOW_LENGTH))
  `ASSERT_IMPLIES(a_ptr_fill, clk, rst_n, !full, wp_r == PTR_W'(cnt_r))
  `ASSERT_NEXT(a_accept_update, clk, rst_n, in_acc, state_r == ST_UPDATE)
  `ASSERT_IMPLIES(a_div_busy, clk, rst_n, state_r == ST_UPDATE, vdone && cdone)

endmodule

`default_nettype wire
